### hdl/pbs_pkg.sv
// package for the page break splitter: item structs, break rule codes,
// sequencer states and the shared arithmetic unit interface
// no dependencies
`default_nettype none

package pbs_pkg;

    localparam int COORD_W = 31;
    localparam int PH_W    = 16;
    localparam int IDX_W   = 16;
    localparam int ALU_W   = 32;
    localparam int REM_W   = PH_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [PH_W-1:0]      PH_RESET = 16'd800;
    localparam logic [IDX_W-1:0]     IDX_MAX  = '1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COORD_W - 1);

    // break rule codes
    localparam logic [1:0] RULE_AUTO   = 2'd0;
    localparam logic [1:0] RULE_AVOID  = 2'd1;
    localparam logic [1:0] RULE_ALWAYS = 2'd2;

    // request codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] line_start;
        logic [COORD_W-1:0] line_end;
        logic [1:0]         break_before;
        logic [1:0]         break_after;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] page_start;
        logic [COORD_W-1:0] page_span;
        logic [IDX_W-1:0]   page_index;
        logic               slices_dropped;
        logic               last_of_run;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_FIN,
        ST_BACK,
        ST_FIT,
        ST_FITC,
        ST_ASPAN,
        ST_BSPAN,
        ST_OPEN,
        ST_DPREP,
        ST_DIV,
        ST_CTOP1,
        ST_CTOP2,
        ST_DISP,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_EMIT_C
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic             busy;
        logic             started;
        logic [IDX_W-1:0] page_cnt;
    } t_core_status;

endpackage

`default_nettype wire

### hdl/pbs_alu.sv
// shared 32-bit add / subtract unit with borrow flag
// depends on pbs_pkg
`default_nettype none

module pbs_alu (
    input  wire pbs_pkg::t_alu_req i_req,
    output pbs_pkg::t_alu_rsp      o_rsp
);

    logic [pbs_pkg::ALU_W-1:0] w_b;
    logic                      w_cin;
    logic [pbs_pkg::ALU_W:0]   w_full;

    always_comb begin
        w_cin  = (i_req.op == pbs_pkg::ALU_SUB);
        w_b    = w_cin ? ~i_req.b : i_req.b;
        w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{pbs_pkg::ALU_W{1'b0}}, w_cin};
        o_rsp.res    = w_full[pbs_pkg::ALU_W-1:0];
        // carry out of a subtract is the inverted borrow
        o_rsp.borrow = w_cin && !w_full[pbs_pkg::ALU_W];
    end

endmodule

`default_nettype wire

### hdl/pbs_out_stage.sv
// output register stage for page items, valid / stall handshake
// depends on pbs_pkg
`default_nettype none

module pbs_out_stage (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire pbs_pkg::t_out_item i_data,
    output logic                    o_can_load,
    output logic                    o_valid,
    input  wire                     i_stall,
    output pbs_pkg::t_out_item      o_data
);

    logic               r_valid;
    pbs_pkg::t_out_item r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_can_load = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

endmodule

`default_nettype wire

### hdl/pbs_core.sv
// sequencer and datapath of the page break splitter: pagination state,
// restoring divider and page emission, all through one shared add / subtract unit
// depends on pbs_pkg, pbs_alu
`default_nettype none

module pbs_core #(
    parameter int MAX_SLICES = 62
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    input  wire pbs_pkg::t_in_item     i_in_data,
    output logic                       o_in_stall,
    input  wire [pbs_pkg::PH_W-1:0]    i_ph,
    input  wire                        i_can_load,
    output logic                       o_load,
    output pbs_pkg::t_out_item         o_out_data,
    output pbs_pkg::t_core_status      o_status
);

    localparam int CNT_W = $clog2(MAX_SLICES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLICES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [pbs_pkg::COORD_W-1:0] MAX_Q = pbs_pkg::COORD_W'(MAX_SLICES);

    pbs_pkg::t_state r_state, n_state;

    // item being worked on
    logic                          r_req;
    logic [pbs_pkg::COORD_W-1:0]   r_ls, r_le, r_span;
    logic [1:0]                    r_bb, r_ba, r_rule;
    logic [pbs_pkg::ALU_W-1:0]     r_tmp;
    logic [pbs_pkg::COORD_W-1:0]   r_a_top, r_a_span, r_b_top, r_b_span, r_cut_top;
    logic                          r_do_a, r_do_b, r_drop;
    logic [CNT_W-1:0]              r_cnt;
    logic [pbs_pkg::COORD_W-1:0]   r_dvd;
    logic [pbs_pkg::REM_W-1:0]     r_rem;
    logic [pbs_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // pagination state
    logic                          r_started;
    logic [pbs_pkg::COORD_W-1:0]   r_cur_top, r_brk_end, r_res_top, r_prev_end;
    logic                          r_brk_valid, r_res_valid;
    logic [1:0]                    r_prev_ba;
    logic [pbs_pkg::IDX_W-1:0]     r_page_cnt;

    pbs_pkg::t_alu_req             w_alu_req;
    pbs_pkg::t_alu_rsp             w_alu_rsp;
    logic [pbs_pkg::ALU_W-1:0]     w_ph32;
    logic [pbs_pkg::COORD_W-1:0]   w_le_clamp;
    logic                          w_fit, w_avoid_pop;
    logic [1:0]                    w_rule;
    logic [pbs_pkg::REM_W:0]       w_trial;
    logic                          w_q_over;
    logic [CNT_W-1:0]              w_shown;
    logic [pbs_pkg::IDX_W-1:0]     w_cnt_inc;

    pbs_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    always_comb begin
        w_ph32      = {{(pbs_pkg::ALU_W - pbs_pkg::PH_W){1'b0}}, i_ph};
        w_le_clamp  = w_alu_rsp.borrow ? r_ls : r_le;
        w_fit       = !w_alu_rsp.borrow;
        w_avoid_pop = !w_fit && (r_rule == pbs_pkg::RULE_AVOID) && r_brk_valid && r_res_valid;
        if (r_prev_ba == pbs_pkg::RULE_AVOID || r_bb == pbs_pkg::RULE_AVOID) begin
            w_rule = pbs_pkg::RULE_AVOID;
        end else if (r_prev_ba == pbs_pkg::RULE_ALWAYS || r_bb == pbs_pkg::RULE_ALWAYS) begin
            w_rule = pbs_pkg::RULE_ALWAYS;
        end else begin
            w_rule = pbs_pkg::RULE_AUTO;
        end
        w_trial   = {r_rem, r_dvd[pbs_pkg::COORD_W-1]};
        w_q_over  = r_dvd > MAX_Q;
        w_shown   = w_q_over ? MAX_CNT : r_dvd[CNT_W-1:0];
        w_cnt_inc = (r_page_cnt == pbs_pkg::IDX_MAX) ? r_page_cnt : r_page_cnt + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = pbs_pkg::ST_CLAMP;
            end
            pbs_pkg::ST_CLAMP: begin
                if (r_req == pbs_pkg::REQ_FINISH) n_state = pbs_pkg::ST_FIN;
                else if (r_started)               n_state = pbs_pkg::ST_BACK;
                else                              n_state = pbs_pkg::ST_OPEN;
            end
            pbs_pkg::ST_FIN: begin
                n_state = r_started ? pbs_pkg::ST_EMIT_B : pbs_pkg::ST_IDLE;
            end
            pbs_pkg::ST_BACK: begin
                // slice running backward is dropped silently
                n_state = w_alu_rsp.borrow ? pbs_pkg::ST_IDLE : pbs_pkg::ST_FIT;
            end
            pbs_pkg::ST_FIT: n_state = pbs_pkg::ST_FITC;
            pbs_pkg::ST_FITC: begin
                if (w_avoid_pop) begin
                    n_state = pbs_pkg::ST_ASPAN;
                end else if (!w_fit || r_rule == pbs_pkg::RULE_ALWAYS) begin
                    n_state = pbs_pkg::ST_BSPAN;
                end else begin
                    n_state = pbs_pkg::ST_DISP;
                end
            end
            pbs_pkg::ST_ASPAN: n_state = pbs_pkg::ST_FIT;
            pbs_pkg::ST_BSPAN: n_state = pbs_pkg::ST_OPEN;
            pbs_pkg::ST_OPEN: begin
                n_state = w_alu_rsp.borrow ? pbs_pkg::ST_DPREP : pbs_pkg::ST_DISP;
            end
            pbs_pkg::ST_DPREP: n_state = pbs_pkg::ST_DIV;
            pbs_pkg::ST_DIV: begin
                if (r_div_cnt == '0) n_state = pbs_pkg::ST_CTOP1;
            end
            pbs_pkg::ST_CTOP1: n_state = pbs_pkg::ST_CTOP2;
            pbs_pkg::ST_CTOP2: n_state = pbs_pkg::ST_DISP;
            pbs_pkg::ST_DISP: begin
                if (r_do_a)            n_state = pbs_pkg::ST_EMIT_A;
                else if (r_do_b)       n_state = pbs_pkg::ST_EMIT_B;
                else if (r_cnt != '0)  n_state = pbs_pkg::ST_EMIT_C;
                else                   n_state = pbs_pkg::ST_IDLE;
            end
            pbs_pkg::ST_EMIT_A: begin
                if (i_can_load) begin
                    if (r_do_b)           n_state = pbs_pkg::ST_EMIT_B;
                    else if (r_cnt != '0) n_state = pbs_pkg::ST_EMIT_C;
                    else                  n_state = pbs_pkg::ST_IDLE;
                end
            end
            pbs_pkg::ST_EMIT_B: begin
                if (i_can_load) begin
                    n_state = (r_cnt != '0) ? pbs_pkg::ST_EMIT_C : pbs_pkg::ST_IDLE;
                end
            end
            pbs_pkg::ST_EMIT_C: begin
                if (i_can_load && r_cnt == CNT_ONE) n_state = pbs_pkg::ST_IDLE;
            end
            default: n_state = pbs_pkg::ST_IDLE;
        endcase
    end

    // outputs: unit operands, page item, handshake
    always_comb begin
        w_alu_req.op = pbs_pkg::ALU_SUB;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        o_load       = 1'b0;
        o_out_data.page_start     = r_b_top;
        o_out_data.page_span      = r_b_span;
        o_out_data.page_index     = r_page_cnt;
        o_out_data.slices_dropped = r_drop;
        o_out_data.last_of_run    = (r_cnt == '0);
        case (r_state)
            pbs_pkg::ST_CLAMP: begin
                w_alu_req.a = {1'b0, r_le};
                w_alu_req.b = {1'b0, r_ls};
            end
            pbs_pkg::ST_FIN, pbs_pkg::ST_BSPAN: begin
                w_alu_req.a = {1'b0, r_prev_end};
                w_alu_req.b = {1'b0, r_cur_top};
            end
            pbs_pkg::ST_BACK: begin
                w_alu_req.a = {1'b0, r_ls};
                w_alu_req.b = {1'b0, r_prev_end};
            end
            pbs_pkg::ST_FIT: begin
                w_alu_req.a = {1'b0, r_le};
                w_alu_req.b = {1'b0, r_cur_top};
            end
            pbs_pkg::ST_FITC: begin
                w_alu_req.a = w_ph32;
                w_alu_req.b = r_tmp;
            end
            pbs_pkg::ST_ASPAN: begin
                w_alu_req.a = {1'b0, r_brk_end};
                w_alu_req.b = {1'b0, r_cur_top};
            end
            pbs_pkg::ST_OPEN: begin
                w_alu_req.a = w_ph32;
                w_alu_req.b = {1'b0, r_span};
            end
            pbs_pkg::ST_DPREP: begin
                w_alu_req.a = {1'b0, r_span};
                w_alu_req.b = pbs_pkg::ALU_W'(1);
            end
            pbs_pkg::ST_DIV: begin
                w_alu_req.a = pbs_pkg::ALU_W'(w_trial);
                w_alu_req.b = w_ph32;
            end
            pbs_pkg::ST_CTOP1: begin
                w_alu_req.a = {1'b0, r_le};
                w_alu_req.b = pbs_pkg::ALU_W'(r_rem);
            end
            pbs_pkg::ST_CTOP2: begin
                w_alu_req.a = r_tmp;
                w_alu_req.b = pbs_pkg::ALU_W'(1);
            end
            pbs_pkg::ST_EMIT_A: begin
                o_load = i_can_load;
                o_out_data.page_start  = r_a_top;
                o_out_data.page_span   = r_a_span;
                o_out_data.last_of_run = !r_do_b && (r_cnt == '0);
            end
            pbs_pkg::ST_EMIT_B: begin
                o_load = i_can_load;
            end
            pbs_pkg::ST_EMIT_C: begin
                o_load = i_can_load;
                w_alu_req.op = pbs_pkg::ALU_ADD;
                w_alu_req.a  = {1'b0, r_cut_top};
                w_alu_req.b  = w_ph32;
                o_out_data.page_start  = r_cut_top;
                o_out_data.page_span   = pbs_pkg::COORD_W'(i_ph);
                o_out_data.last_of_run = (r_cnt == CNT_ONE);
            end
            default: begin
                w_alu_req.op = pbs_pkg::ALU_SUB;
            end
        endcase
        o_in_stall       = (r_state != pbs_pkg::ST_IDLE);
        o_status.busy     = (r_state != pbs_pkg::ST_IDLE);
        o_status.started  = r_started;
        o_status.page_cnt = r_page_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pagination state and per-item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_cur_top   <= '0;
            r_brk_end   <= '0;
            r_brk_valid <= 1'b0;
            r_res_top   <= '0;
            r_res_valid <= 1'b0;
            r_prev_end  <= '0;
            r_prev_ba   <= pbs_pkg::RULE_AUTO;
            r_page_cnt  <= '0;
            r_do_a      <= 1'b0;
            r_do_b      <= 1'b0;
            r_drop      <= 1'b0;
            r_cnt       <= '0;
            r_div_cnt   <= '0;
        end else begin
            case (r_state)
                pbs_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_do_a <= 1'b0;
                        r_do_b <= 1'b0;
                        r_drop <= 1'b0;
                        r_cnt  <= '0;
                    end
                end
                pbs_pkg::ST_CLAMP: begin
                    if (r_req == pbs_pkg::REQ_ADD && !r_started) begin
                        r_started  <= 1'b1;
                        r_prev_end <= w_le_clamp;
                        r_prev_ba  <= r_ba;
                    end
                end
                pbs_pkg::ST_FIN: begin
                    if (r_started) begin
                        r_do_b <= 1'b1;
                    end else begin
                        r_cur_top   <= '0;
                        r_brk_end   <= '0;
                        r_brk_valid <= 1'b0;
                        r_res_top   <= '0;
                        r_res_valid <= 1'b0;
                        r_prev_end  <= '0;
                        r_prev_ba   <= pbs_pkg::RULE_AUTO;
                        r_page_cnt  <= '0;
                    end
                end
                pbs_pkg::ST_FITC: begin
                    if (!w_avoid_pop && w_fit && r_rule != pbs_pkg::RULE_ALWAYS) begin
                        // slice stacks onto the page; an auto break is a fallback point
                        if (r_rule == pbs_pkg::RULE_AUTO) begin
                            r_brk_end   <= r_prev_end;
                            r_brk_valid <= 1'b1;
                            r_res_top   <= r_ls;
                            r_res_valid <= 1'b1;
                        end
                        r_prev_end <= r_le;
                        r_prev_ba  <= r_ba;
                    end
                end
                pbs_pkg::ST_ASPAN: begin
                    r_do_a      <= 1'b1;
                    r_cur_top   <= r_res_top;
                    r_brk_valid <= 1'b0;
                    r_res_valid <= 1'b0;
                end
                pbs_pkg::ST_BSPAN: begin
                    r_do_b     <= 1'b1;
                    r_prev_end <= r_le;
                    r_prev_ba  <= r_ba;
                end
                pbs_pkg::ST_OPEN: begin
                    r_cur_top   <= r_ls;
                    r_brk_valid <= 1'b0;
                    r_res_valid <= 1'b0;
                end
                pbs_pkg::ST_DPREP: begin
                    r_div_cnt <= pbs_pkg::DIV_LAST;
                end
                pbs_pkg::ST_DIV: begin
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
                pbs_pkg::ST_CTOP1: begin
                    r_drop <= w_q_over;
                    r_cnt  <= w_shown;
                end
                pbs_pkg::ST_CTOP2: begin
                    // top of the remainder page: line_end - 1 - ((span - 1) mod page)
                    r_cur_top <= w_alu_rsp.res[pbs_pkg::COORD_W-1:0];
                end
                pbs_pkg::ST_EMIT_A: begin
                    if (i_can_load) r_page_cnt <= w_cnt_inc;
                end
                pbs_pkg::ST_EMIT_B: begin
                    if (i_can_load) begin
                        if (r_req == pbs_pkg::REQ_FINISH) begin
                            r_started   <= 1'b0;
                            r_cur_top   <= '0;
                            r_brk_end   <= '0;
                            r_brk_valid <= 1'b0;
                            r_res_top   <= '0;
                            r_res_valid <= 1'b0;
                            r_prev_end  <= '0;
                            r_prev_ba   <= pbs_pkg::RULE_AUTO;
                            r_page_cnt  <= '0;
                        end else begin
                            r_page_cnt <= w_cnt_inc;
                        end
                    end
                end
                pbs_pkg::ST_EMIT_C: begin
                    if (i_can_load) begin
                        r_page_cnt <= w_cnt_inc;
                        r_cnt      <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_do_a <= r_do_a;
                end
            endcase
        end
    end

    // item payload and scratch values
    always_ff @(posedge i_clk) begin
        case (r_state)
            pbs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_req <= i_in_data.req_type;
                    r_ls  <= i_in_data.line_start;
                    r_le  <= i_in_data.line_end;
                    r_bb  <= i_in_data.break_before;
                    r_ba  <= i_in_data.break_after;
                end
            end
            pbs_pkg::ST_CLAMP: begin
                r_le   <= w_le_clamp;
                r_span <= w_alu_rsp.borrow ? '0 : w_alu_rsp.res[pbs_pkg::COORD_W-1:0];
            end
            pbs_pkg::ST_FIN: begin
                r_b_top  <= r_cur_top;
                r_b_span <= w_alu_rsp.res[pbs_pkg::COORD_W-1:0];
            end
            pbs_pkg::ST_BACK: begin
                r_rule <= w_rule;
            end
            pbs_pkg::ST_FIT, pbs_pkg::ST_CTOP1: begin
                r_tmp <= w_alu_rsp.res;
            end
            pbs_pkg::ST_ASPAN: begin
                r_a_top  <= r_cur_top;
                r_a_span <= w_alu_rsp.res[pbs_pkg::COORD_W-1:0];
            end
            pbs_pkg::ST_BSPAN: begin
                r_b_top  <= r_cur_top;
                r_b_span <= w_alu_rsp.res[pbs_pkg::COORD_W-1:0];
            end
            pbs_pkg::ST_OPEN: begin
                r_cut_top <= r_ls;
            end
            pbs_pkg::ST_DPREP: begin
                r_dvd <= w_alu_rsp.res[pbs_pkg::COORD_W-1:0];
                r_rem <= '0;
            end
            pbs_pkg::ST_DIV: begin
                // restoring step, quotient bits shift in behind the dividend
                if (w_alu_rsp.borrow) begin
                    r_rem <= w_trial[pbs_pkg::REM_W-1:0];
                end else begin
                    r_rem <= w_alu_rsp.res[pbs_pkg::REM_W-1:0];
                end
                r_dvd <= {r_dvd[pbs_pkg::COORD_W-2:0], !w_alu_rsp.borrow};
            end
            pbs_pkg::ST_EMIT_C: begin
                if (i_can_load) r_cut_top <= w_alu_rsp.res[pbs_pkg::COORD_W-1:0];
            end
            default: begin
                r_rule <= r_rule;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/page_break_splitter_unit.sv
// Page break splitter: packs document slices greedily into pages of page_height
// (a value of 0 acts as 1) and emits one item per page with its top, span, running
// index, a dropped-slices flag and a last-of-run flag. One input item is taken at a
// time; the input stalls until that item's work is done and its last page is handed
// to the output register. The coordinate, span and divider arithmetic goes through
// one shared 32-bit add/subtract unit, one operation per cycle. A slice that runs
// backward is ignored. A slice taller than a page also runs a restoring divide
// of its span minus one by the page height, one quotient bit per cycle, then
// emits its cut pages one per cycle while the output does not stall, at most
// MAX_SLICES of them. An output stall holds back the page being handed over while
// the output register is full. A page_height write is taken in any cycle (its
// ready is always high) and should only come while no item is in flight.
// depends on pbs_pkg, pbs_core, pbs_out_stage
`default_nettype none

module page_break_splitter_unit #(
    parameter int MAX_SLICES = 62
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire pbs_pkg::t_in_item     i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output pbs_pkg::t_out_item         o_out_data,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [pbs_pkg::PH_W-1:0]    i_cfg_data
);

    logic [pbs_pkg::PH_W-1:0] r_page_height;
    logic [pbs_pkg::PH_W-1:0] w_ph;
    logic                     w_can_load;
    logic                     w_load;
    pbs_pkg::t_out_item       w_page;
    pbs_pkg::t_core_status    w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_height <= pbs_pkg::PH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_page_height <= i_cfg_data;
        end
    end

    assign w_ph = (r_page_height == '0) ? pbs_pkg::PH_W'(1) : r_page_height;

    pbs_core #(
        .MAX_SLICES (MAX_SLICES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_ph       (w_ph),
        .i_can_load (w_can_load),
        .o_load     (w_load),
        .o_out_data (w_page),
        .o_status   (w_status)
    );

    pbs_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_data     (w_page),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

    // an accepted item always makes the sequencer busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_status.busy)
        else $error("sequencer not busy after accepting an item");

    // after a page that is not the last one, another page is queued or coming
    a_more_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_of_run)
            |=> (o_out_valid || w_status.busy))
        else $error("run ended without a last page");

    // no page can be counted before the first slice of a document
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.started |-> (w_status.page_cnt == '0))
        else $error("page count nonzero outside a document");

endmodule

`default_nettype wire
